@@ src/kred_pkg.sv @@
// kred_pkg: shared types and constants of the keyboard report event differ
// no dependencies

package kred_pkg;

  localparam int IN_SLOTS = 6;   // key slot fields carried by one input word
  localparam int CODE_W   = 16;
  localparam int MOD_W    = 8;

  // reserved keycodes read as an empty slot
  localparam logic [CODE_W-1:0] RSV_LO    = 16'h0001;
  localparam logic [CODE_W-1:0] RSV_HI    = 16'h0003;
  localparam logic [CODE_W-1:0] CODE_MASK = 16'hFFFF;

  // event kinds
  localparam logic [1:0] EV_MOD_PRESS   = 2'd0;
  localparam logic [1:0] EV_MOD_RELEASE = 2'd1;
  localparam logic [1:0] EV_KEY_PRESS   = 2'd2;
  localparam logic [1:0] EV_KEY_RELEASE = 2'd3;

  // register indexes
  localparam logic [1:0] REG_ENABLED   = 2'd0;
  localparam logic [1:0] REG_SLOTS     = 2'd1;
  localparam logic [1:0] REG_MOD_PRES  = 2'd2;

  typedef struct packed {
    logic             enabled;
    logic [2:0]       key_slots_used;
    logic [MOD_W-1:0] modifier_present;
  } cfg_t;

  typedef struct packed {
    logic load;      // take a new current code, clear visited marks
    logic rot_cur;   // current codes move one cell toward the head
    logic rot_prev;  // previous codes move one cell toward the head
    logic commit;    // previous <= current
    logic sel_rel;   // compare for releases instead of presses
  } cell_ctrl_t;

  typedef struct packed {
    logic dup;       // candidate already seen among visited words
    logic other;     // candidate present in the other list
  } hit_t;

endpackage

@@ src/kred_in_if.sv @@
// kred_in_if: input channel carrying one keyboard report word
// depends on kred_pkg

interface kred_in_if;
  import kred_pkg::*;

  logic              valid;
  logic              ready;
  logic [MOD_W-1:0]  modifier_bits;
  logic [CODE_W-1:0] key_slot_0;
  logic [CODE_W-1:0] key_slot_1;
  logic [CODE_W-1:0] key_slot_2;
  logic [CODE_W-1:0] key_slot_3;
  logic [CODE_W-1:0] key_slot_4;
  logic [CODE_W-1:0] key_slot_5;

  modport source (
    output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
           key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );

  modport sink (
    input  valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
           key_slot_3, key_slot_4, key_slot_5,
    output ready
  );

endinterface

@@ src/kred_out_if.sv @@
// kred_out_if: output channel carrying one key event word
// depends on kred_pkg

interface kred_out_if;
  import kred_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [CODE_W-1:0] event_code;
  logic              last_event;

  modport source (
    output valid, event_kind, event_code, last_event,
    input  ready
  );

  modport sink (
    input  valid, event_kind, event_code, last_event,
    output ready
  );

endinterface

@@ src/kred_apb_regs.sv @@
// kred_apb_regs: apb-style configuration registers
// depends on kred_pkg

module kred_apb_regs
  import kred_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLED:  cfg_d.enabled          = pwdata[0];
        REG_SLOTS:    cfg_d.key_slots_used   = pwdata[2:0];
        REG_MOD_PRES: cfg_d.modifier_present = pwdata[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLED:  prdata = {31'd0, cfg_q.enabled};
      REG_SLOTS:    prdata = {29'd0, cfg_q.key_slots_used};
      REG_MOD_PRES: prdata = {24'd0, cfg_q.modifier_present};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled          <= 1'b1;
      cfg_q.key_slots_used   <= 3'd6;
      cfg_q.modifier_present <= 8'hFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/kred_cell.sv @@
// kred_cell: one key slot of the differ chain, holds a previous and a current code
// depends on kred_pkg

module kred_cell
  import kred_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CODE_W-1:0] load_code_i,
  input  logic [CODE_W-1:0] cand_i,
  input  logic [CODE_W-1:0] cur_nb_i,
  input  logic              cur_vis_nb_i,
  input  logic [CODE_W-1:0] prev_nb_i,
  input  logic              prev_vis_nb_i,
  input  hit_t              hit_i,
  output logic [CODE_W-1:0] cur_o,
  output logic              cur_vis_o,
  output logic [CODE_W-1:0] prev_o,
  output logic              prev_vis_o,
  output hit_t              hit_o
);

  logic [CODE_W-1:0] cur_q, prev_q;
  logic              cur_vis_q, prev_vis_q;
  logic              cur_eq, prev_eq;

  assign cur_eq  = (cur_q == cand_i);
  assign prev_eq = (prev_q == cand_i);

  // match flags ripple toward the head cell
  always_comb begin
    hit_o = hit_i;
    if (ctrl_i.sel_rel) begin
      hit_o.dup   = hit_i.dup   | (prev_vis_q & prev_eq);
      hit_o.other = hit_i.other | cur_eq;
    end else begin
      hit_o.dup   = hit_i.dup   | (cur_vis_q & cur_eq);
      hit_o.other = hit_i.other | prev_eq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cur_q <= load_code_i;
    end else if (ctrl_i.rot_cur) begin
      cur_q <= cur_nb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      cur_vis_q  <= 1'b0;
      prev_vis_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        cur_vis_q  <= 1'b0;
        prev_vis_q <= 1'b0;
      end else begin
        if (ctrl_i.rot_cur) begin
          cur_vis_q <= cur_vis_nb_i;
        end
        if (ctrl_i.rot_prev) begin
          prev_vis_q <= prev_vis_nb_i;
        end
      end
      if (ctrl_i.commit) begin
        prev_q <= cur_q;
      end else if (ctrl_i.rot_prev) begin
        prev_q <= prev_nb_i;
      end
    end
  end

  assign cur_o      = cur_q;
  assign cur_vis_o  = cur_vis_q;
  assign prev_o     = prev_q;
  assign prev_vis_o = prev_vis_q;

endmodule

@@ src/keyboard_report_event_differ_top.sv @@
// keyboard report event differ: one report word in, a run of key event words out.
// the sequencer visits each modifier bit, then each current slot, then each previous
// slot, one per cycle while the output register is free, rotating the cell row during
// the slot visits, then takes a finish step that commits the report.
// one report in flight at a time; output stalls freeze the sequence.
// reset: previous modifiers and keys clear to zero, registers take their defaults.

module keyboard_report_event_differ_top
  import kred_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kred_in_if.sink     in_i,
  kred_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_MAX = (KEY_SLOTS > MOD_W) ? KEY_SLOTS : MOD_W;
  localparam int CW      = $clog2(CNT_MAX);
  localparam logic [CW-1:0] MOD_LAST = CW'(MOD_W - 1);
  localparam logic [CW-1:0] KEY_LAST = CW'(KEY_SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_PRESS = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  cfg_t cfg;

  kred_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [MOD_W-1:0]  mods_q, mods_d, pmod_q, pmod_d;
  logic              out_vld_q, out_vld_d, out_last_q, out_last_d;
  logic [1:0]        out_kind_q, out_kind_d, hold_kind_q, hold_kind_d;
  logic [CODE_W-1:0] out_code_q, out_code_d, hold_code_q, hold_code_d;
  logic              hold_vld_q, hold_vld_d;

  logic              accept, adv;
  cell_ctrl_t        ctrl;
  logic              ev_found;
  logic [1:0]        ev_kind;
  logic [CODE_W-1:0] ev_code;
  logic [CODE_W-1:0] cand;
  logic [2:0]        bit_idx;

  logic [CODE_W-1:0] in_slot  [IN_SLOTS];
  logic [CODE_W-1:0] cur_w    [KEY_SLOTS];
  logic [CODE_W-1:0] prev_w   [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] cur_vis_w, prev_vis_w;
  hit_t              hit_w    [KEY_SLOTS+1];

  assign in_slot[0] = in_i.key_slot_0;
  assign in_slot[1] = in_i.key_slot_1;
  assign in_slot[2] = in_i.key_slot_2;
  assign in_slot[3] = in_i.key_slot_3;
  assign in_slot[4] = in_i.key_slot_4;
  assign in_slot[5] = in_i.key_slot_5;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  // the sequencer steps only when the output register can take a word
  assign adv        = !out_vld_q || out_o.ready;

  assign ctrl.load     = accept && cfg.enabled;
  assign ctrl.rot_cur  = (state_q == S_PRESS) && adv;
  assign ctrl.rot_prev = (state_q == S_REL) && adv;
  assign ctrl.commit   = (state_q == S_FIN) && adv;
  assign ctrl.sel_rel  = (state_q == S_REL);

  assign hit_w[KEY_SLOTS] = '0;
  assign cand = ctrl.sel_rel ? prev_w[0] : cur_w[0];

  for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_cell
    localparam int NK = (k + 1) % KEY_SLOTS;
    logic [CODE_W-1:0] load_code;
    logic              cur_vis_nb, prev_vis_nb;

    if (k < IN_SLOTS) begin : g_in
      logic rsv;
      assign rsv = (in_slot[k] >= RSV_LO) && (in_slot[k] <= RSV_HI);
      assign load_code = ((k < int'(cfg.key_slots_used)) && !rsv) ?
                         (in_slot[k] & CODE_MASK) : '0;
    end else begin : g_empty
      assign load_code = '0;
    end

    // the word wrapping from the head into the tail has been visited
    if (k == KEY_SLOTS - 1) begin : g_tail
      assign cur_vis_nb  = 1'b1;
      assign prev_vis_nb = 1'b1;
    end else begin : g_mid
      assign cur_vis_nb  = cur_vis_w[NK];
      assign prev_vis_nb = prev_vis_w[NK];
    end

    kred_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .load_code_i   (load_code),
      .cand_i        (cand),
      .cur_nb_i      (cur_w[NK]),
      .cur_vis_nb_i  (cur_vis_nb),
      .prev_nb_i     (prev_w[NK]),
      .prev_vis_nb_i (prev_vis_nb),
      .hit_i         (hit_w[k+1]),
      .cur_o         (cur_w[k]),
      .cur_vis_o     (cur_vis_w[k]),
      .prev_o        (prev_w[k]),
      .prev_vis_o    (prev_vis_w[k]),
      .hit_o         (hit_w[k])
    );
  end

  assign bit_idx = cnt_q[2:0];

  always_comb begin
    ev_found = 1'b0;
    ev_kind  = EV_MOD_PRESS;
    ev_code  = '0;
    unique case (state_q)
      S_MOD: begin
        ev_found = mods_q[bit_idx] ^ pmod_q[bit_idx];
        ev_kind  = mods_q[bit_idx] ? EV_MOD_PRESS : EV_MOD_RELEASE;
        ev_code  = CODE_W'(bit_idx);
      end
      S_PRESS, S_REL: begin
        ev_found = (cand != '0) && !hit_w[0].dup && !hit_w[0].other;
        ev_kind  = ctrl.sel_rel ? EV_KEY_RELEASE : EV_KEY_PRESS;
        ev_code  = cand;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mods_d      = mods_q;
    pmod_d      = pmod_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;
    hold_vld_d  = hold_vld_q;
    hold_kind_d = hold_kind_q;
    hold_code_d = hold_code_q;

    // each new event pushes the held one out; the held one is known last at the end
    if (adv && ev_found) begin
      if (hold_vld_q) begin
        out_vld_d  = 1'b1;
        out_kind_d = hold_kind_q;
        out_code_d = hold_code_q;
        out_last_d = 1'b0;
      end
      hold_vld_d  = 1'b1;
      hold_kind_d = ev_kind;
      hold_code_d = ev_code;
    end

    unique case (state_q)
      S_IDLE: begin
        if (ctrl.load) begin
          mods_d  = in_i.modifier_bits & cfg.modifier_present;
          cnt_d   = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (adv) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == MOD_LAST) begin
            cnt_d   = '0;
            state_d = S_PRESS;
          end
        end
      end
      S_PRESS: begin
        if (adv) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == KEY_LAST) begin
            cnt_d   = '0;
            state_d = S_REL;
          end
        end
      end
      S_REL: begin
        if (adv) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == KEY_LAST) begin
            cnt_d   = '0;
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (adv) begin
          if (hold_vld_q) begin
            out_vld_d  = 1'b1;
            out_kind_d = hold_kind_q;
            out_code_d = hold_code_q;
            out_last_d = 1'b1;
            hold_vld_d = 1'b0;
          end
          pmod_d  = mods_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      pmod_q     <= '0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pmod_q     <= pmod_d;
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mods_q      <= mods_d;
    out_kind_q  <= out_kind_d;
    out_code_q  <= out_code_d;
    out_last_q  <= out_last_d;
    hold_kind_q <= hold_kind_d;
    hold_code_q <= hold_code_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.event_kind = out_kind_q;
  assign out_o.event_code = out_code_q;
  assign out_o.last_event = out_last_q;

  // no held event may survive into idle, or it would be merged into the next run
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_vld_q)
    else $error("held event pending while idle");

  // the last word of a run is shown only once nothing is held behind it
  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_last_q) |-> !hold_vld_q)
    else $error("last event shown with an event still held");

  a_fin_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && adv) |=> (state_q == S_IDLE))
    else $error("finish step did not return to idle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRESS || state_q == S_REL) |-> (cnt_q <= KEY_LAST))
    else $error("slot counter beyond the cell row");

  // previous codes change only on the finish commit or while rotating
  a_prev_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_MOD || state_q == S_PRESS) |=>
      $stable(prev_w[0]))
    else $error("previous key changed outside release scan or commit");

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking bench for keyboard_report_event_differ_top, reports in, key events out
// depends on kred_pkg, kred_in_if, kred_out_if and the top level; an event scoreboard
// predicts each word from its own copy of the register and previous-report state

module tb;
  import kred_pkg::*;

  localparam int KEY_SLOTS   = 6;
  localparam int IDLE_CYCLES = 2 * KEY_SLOTS + 28;
  localparam int N_PHASES    = 7;

  typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_list_t;

  typedef struct packed {
    logic [MOD_W-1:0]                 mods;
    logic [IN_SLOTS-1:0][CODE_W-1:0]  keys;
  } report_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CODE_W-1:0] code;
    logic              last_ev;
  } key_event_t;

  class event_scoreboard;
    key_event_t       pending[$];
    int               errors;
    int               reports;
    int               events;
    int               kind_seen[4];
    logic             en;
    logic [2:0]       slots;
    logic [MOD_W-1:0] mod_pres;
    logic [MOD_W-1:0] held_mods;
    key_list_t        held_keys;

    function new();
      errors    = 0;
      reports   = 0;
      events    = 0;
      kind_seen = '{default: 0};
      en        = 1'b1;
      slots     = 3'd6;
      mod_pres  = '1;
      held_mods = '0;
      held_keys = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ENABLED:  en = val[0];
        REG_SLOTS:    slots = val[2:0];
        REG_MOD_PRES: mod_pres = val[MOD_W-1:0];
        default: ;
      endcase
    endfunction

    function bit holds(key_list_t list, int n, logic [CODE_W-1:0] code);
      int i;
      if (code == '0) return 1'b0;
      for (i = 0; i < n; i++)
        if (list[i] == code) return 1'b1;
      return 1'b0;
    endfunction

    function void push_event(logic [1:0] kind, logic [CODE_W-1:0] code);
      key_event_t ev;
      ev.kind    = kind;
      ev.code    = code;
      ev.last_ev = 1'b0;
      pending.push_back(ev);
    endfunction

    // one accepted report: queue the events it should cause
    function void note_report(report_t r);
      logic [MOD_W-1:0] mods;
      logic [MOD_W-1:0] changed;
      key_list_t        cur;
      int               used;
      int               n_before;
      int               i;
      reports++;
      if (!en) return;
      n_before = pending.size();
      mods    = r.mods & mod_pres;
      changed = mods ^ held_mods;
      for (i = 0; i < MOD_W; i++)
        if (changed[i]) push_event(mods[i] ? EV_MOD_PRESS : EV_MOD_RELEASE, CODE_W'(i));
      held_mods = mods;

      used = int'(slots);
      if (used > KEY_SLOTS) used = KEY_SLOTS;
      if (used > IN_SLOTS) used = IN_SLOTS;
      for (i = 0; i < KEY_SLOTS; i++) begin
        cur[i] = '0;
        if (i < used && !(r.keys[i] >= RSV_LO && r.keys[i] <= RSV_HI))
          cur[i] = r.keys[i] & CODE_MASK;
      end

      // presses in current slot order, first occurrence only
      for (i = 0; i < KEY_SLOTS; i++)
        if (cur[i] != '0 && !holds(cur, i, cur[i]) && !holds(held_keys, KEY_SLOTS, cur[i]))
          push_event(EV_KEY_PRESS, cur[i]);
      // releases in previous slot order
      for (i = 0; i < KEY_SLOTS; i++)
        if (held_keys[i] != '0 && !holds(held_keys, i, held_keys[i]) &&
            !holds(cur, KEY_SLOTS, held_keys[i]))
          push_event(EV_KEY_RELEASE, held_keys[i]);
      held_keys = cur;

      if (pending.size() > n_before) pending[pending.size()-1].last_ev = 1'b1;
    endfunction

    function void check_event(logic [1:0] kind, logic [CODE_W-1:0] code, logic last_ev);
      key_event_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected event: kind %0d code %h last %0b", $time, kind, code,
                 last_ev);
        return;
      end
      want = pending.pop_front();
      events++;
      kind_seen[kind]++;
      if (kind !== want.kind || code !== want.code || last_ev !== want.last_ev) begin
        errors++;
        $display({"%0t: event mismatch: expected kind %0d code %h last %0b, ",
                  "got kind %0d code %h last %0b"},
                 $time, want.kind, want.code, want.last_ev, kind, code, last_ev);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kred_in_if  in_if ();
  kred_out_if out_if ();

  keyboard_report_event_differ_top #(.KEY_SLOTS(KEY_SLOTS)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  event_scoreboard sb;
  bit              burst;
  report_t         last_sent;

  // register settings per phase: default, single slot, odd masks, disabled,
  // zero slots, oversized slot count, back to full
  bit               ph_en    [N_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  logic [2:0]       ph_slots [N_PHASES] = '{3'd6, 3'd1, 3'd3, 3'd6, 3'd0, 3'd7, 3'd6};
  logic [MOD_W-1:0] ph_mask  [N_PHASES] = '{8'hFF, 8'h00, 8'hA5, 8'hFF, 8'h5A, 8'hFF, 8'h3C};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // output stalls
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) repeat (60) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_event(out_if.event_kind, out_if.event_code, out_if.last_event);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_report(report_t r);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.modifier_bits <= r.mods;
    in_if.key_slot_0    <= r.keys[0];
    in_if.key_slot_1    <= r.keys[1];
    in_if.key_slot_2    <= r.keys[2];
    in_if.key_slot_3    <= r.keys[3];
    in_if.key_slot_4    <= r.keys[4];
    in_if.key_slot_5    <= r.keys[5];
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_report(r);
    last_sent = r;
  endtask

  task automatic send_keys(logic [7:0] mods, logic [15:0] k0, logic [15:0] k1,
                           logic [15:0] k2, logic [15:0] k3, logic [15:0] k4,
                           logic [15:0] k5);
    report_t r;
    r.mods = mods;
    r.keys = {k5, k4, k3, k2, k1, k0};
    send_report(r);
  endtask

  // every result in, then let the sequencer finish a report with no events
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly a held report with a few keys or modifiers changed, sometimes noise
  function automatic report_t next_report(report_t prev);
    report_t r;
    int      i;
    r = prev;
    if ($urandom_range(0, 9) == 0) begin
      r.mods = MOD_W'($urandom);
      for (i = 0; i < IN_SLOTS; i++) r.keys[i] = CODE_W'($urandom_range(0, 65535));
      return r;
    end
    case ($urandom_range(0, 9))
      0:       r.mods = MOD_W'($urandom);
      1, 2, 3: r.mods[$urandom_range(0, 7)] = ~r.mods[$urandom_range(0, 7)];
      default: ;
    endcase
    // keys shifting between slots
    if ($urandom_range(0, 7) == 0) r.keys = {r.keys[0], r.keys[IN_SLOTS-1:1]};
    for (i = 0; i < IN_SLOTS; i++) begin
      case ($urandom_range(0, 19))
        11, 12, 13, 14: r.keys[i] = CODE_W'($urandom_range(4, 12));
        15, 16:         r.keys[i] = CODE_W'($urandom_range(0, 3));
        17:             r.keys[i] = '0;
        18:             r.keys[i] = CODE_W'($urandom_range(0, 65535));
        19:             r.keys[i] = 16'hFFFF - CODE_W'($urandom_range(0, 2));
        default: ;
      endcase
    end
    return r;
  endfunction

  initial begin
    int ph;
    int n_items;
    sb = new();
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_if.valid         <= 1'b0;
    in_if.modifier_bits <= '0;
    in_if.key_slot_0    <= '0;
    in_if.key_slot_1    <= '0;
    in_if.key_slot_2    <= '0;
    in_if.key_slot_3    <= '0;
    in_if.key_slot_4    <= '0;
    in_if.key_slot_5    <= '0;
    last_sent           = '0;
    burst               = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_ENABLED, 32'(ph_en[ph]));
      write_reg(REG_SLOTS, 32'(ph_slots[ph]));
      write_reg(REG_MOD_PRES, 32'(ph_mask[ph]));
      burst = ($urandom_range(0, 2) == 0);
      if (ph == 0) begin
        send_keys(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_keys(8'hFF, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009);
        send_keys(8'hFF, 16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009);
        // reserved codes read as empty
        send_keys(8'h00, 16'hFFFF, 16'h8000, 16'h0004, 16'h0005, 16'h0001, 16'h0002);
        // repeated codes report once
        send_keys(8'h00, 16'h0003, 16'h0003, 16'hFFFF, 16'hFFFF, 16'h000A, 16'h000A);
        send_keys(8'h81, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_keys(8'h7E, 16'h0014, 16'h0015, 16'h0016, 16'h0017, 16'h0018, 16'h0019);
        // every modifier flips and every key changes: longest run
        send_keys(8'h81, 16'h001E, 16'h001F, 16'h0020, 16'h0021, 16'h0022, 16'h0023);
        send_keys(8'h55, 16'h0023, 16'h0022, 16'h0021, 16'h0020, 16'h001F, 16'h001E);
        send_keys(8'hAA, 16'h7FFF, 16'h0023, 16'h0022, 16'h0021, 16'h0020, 16'h001F);
        send_keys(8'hAA, 16'h7FFF, 16'h0023, 16'h0022, 16'h0021, 16'h0020, 16'h001F);
        send_keys(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end
      n_items = ph_en[ph] ? 30 : 10;
      repeat (n_items) send_report(next_report(last_sent));
      in_if.valid <= 1'b0;
    end

    wait_idle();
    $display("covered %0d reports over %0d register settings, %0d events checked",
             sb.reports, N_PHASES, sb.events);
    $display("modifier press/release %0d/%0d, key press/release %0d/%0d",
             sb.kind_seen[EV_MOD_PRESS], sb.kind_seen[EV_MOD_RELEASE],
             sb.kind_seen[EV_KEY_PRESS], sb.kind_seen[EV_KEY_RELEASE]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/kred_pkg.sv
src/kred_in_if.sv
src/kred_out_if.sv
src/kred_apb_regs.sv
src/kred_cell.sv
src/keyboard_report_event_differ_top.sv
tb/sv/tb.sv
